@@ design/sitda_pkg.sv @@
`timescale 1ns / 1ps
package sitda_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int LEN_BITS    = 16;
   localparam int CHAR_BITS   = 8;
   localparam int NIB_BITS    = 4;

   localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'd45;
   localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'd48;
   localparam logic [NIB_BITS-1:0]  RADIX    = 4'd10;
   localparam logic [LEN_BITS-1:0]  LEN_MAX  = '1;

   // number of decimal digits of the largest magnitude, 2**(VALUE_WIDTH-1)
   function automatic int dec_digits(int w);
      logic [64:0] lim;
      logic [64:0] p;
      int n;
      lim = 65'd1 << (w - 1);
      p   = 65'd1;
      n   = 0;
      for (int i = 0; i < 24; i++) begin
         if (p <= lim) begin
            n = n + 1;
            p = p * 65'd10;
         end
      end
      return n;
   endfunction

   localparam int DIGITS     = dec_digits(VALUE_WIDTH);
   localparam int BCD_BITS   = DIGITS * NIB_BITS;
   localparam int CONV_STEPS = (VALUE_WIDTH + NIB_BITS - 1) / NIB_BITS;
   localparam int PAD_BITS   = CONV_STEPS * NIB_BITS;
   localparam int STEP_BITS  = (CONV_STEPS > 1) ? $clog2(CONV_STEPS) : 1;
   localparam int IDX_BITS   = $clog2(DIGITS);

   typedef logic [DIGITS-1:0][NIB_BITS-1:0] digits_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_COUNT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic convert;
      logic count;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic conv_done;
      logic emit_last;
      logic out_free;
   } sts_type;

endpackage

@@ design/sitda_ctrl.sv @@
`timescale 1ns / 1ps
module sitda_ctrl
   import sitda_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.convert = 1'b1;
            if (sts.conv_done) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            cmd.count = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            // advance one character whenever the output slot frees up
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ design/sitda_datapath.sv @@
`timescale 1ns / 1ps
module sitda_datapath
   import sitda_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  logic [LEN_BITS-1:0]        req_base_length,
   input  cmd_type                    cmd,
   output sts_type                    sts,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic [CHAR_BITS-1:0]       rsp_out_char,
   output logic [LEN_BITS-1:0]        rsp_running_length,
   output logic                       rsp_last
);

   logic [PAD_BITS-1:0]  shift_ff;
   logic [PAD_BITS-1:0]  shift_in;
   digits_type           bcd_ff;
   digits_type           bcd_in;
   logic [STEP_BITS-1:0] step_ff;
   logic [IDX_BITS-1:0]  idx_ff;
   logic [IDX_BITS-1:0]  idx_in;
   logic                 neg_ff;
   logic [LEN_BITS-1:0]  len_ff;
   logic [LEN_BITS-1:0]  len_in;
   logic [VALUE_WIDTH-1:0] mag;

   logic                 rsp_valid_ff;
   logic [CHAR_BITS-1:0] char_ff;
   logic [CHAR_BITS-1:0] char_in;
   logic [LEN_BITS-1:0]  rlen_ff;
   logic                 last_ff;

   // most negative value wraps to 2**(VALUE_WIDTH-1), which is its true magnitude
   assign mag = req_value[VALUE_WIDTH-1] ? VALUE_WIDTH'(-req_value)
                                         : VALUE_WIDTH'(req_value);

   // four double-dabble steps per cycle
   always_comb begin
      logic [BCD_BITS-1:0] flat;
      digits_type          b;
      logic [PAD_BITS-1:0] s;
      b = bcd_ff;
      s = shift_ff;
      for (int k = 0; k < NIB_BITS; k++) begin
         for (int j = 0; j < DIGITS; j++) begin
            if (b[j] >= 4'd5) begin
               b[j] = 4'(b[j] + 4'd3);
            end
         end
         flat = b;
         flat = {flat[BCD_BITS-2:0], s[PAD_BITS-1]};
         b    = flat;
         s    = {s[PAD_BITS-2:0], 1'b0};
      end
      bcd_in   = b;
      shift_in = s;
   end

   // position of the leading nonzero digit; zero keeps one digit
   always_comb begin
      idx_in = '0;
      for (int j = 0; j < DIGITS; j++) begin
         if (bcd_ff[j] != 4'd0) begin
            idx_in = IDX_BITS'(j);
         end
      end
   end

   assign len_in  = (len_ff == LEN_MAX) ? len_ff : LEN_BITS'(len_ff + 1'b1);
   assign char_in = neg_ff ? CH_MINUS : CHAR_BITS'(CH_ZERO + {4'd0, bcd_ff[idx_ff]});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         shift_ff <= PAD_BITS'(mag);
         bcd_ff   <= '0;
         len_ff   <= req_base_length;
      end else if (cmd.convert) begin
         shift_ff <= shift_in;
         bcd_ff   <= bcd_in;
      end else if (cmd.emit) begin
         len_ff <= len_in;
      end
      if (cmd.count) begin
         idx_ff <= idx_in;
      end else if (cmd.emit && !neg_ff) begin
         idx_ff <= IDX_BITS'(idx_ff - 1'b1);
      end
      if (cmd.emit) begin
         char_ff <= char_in;
         rlen_ff <= len_in;
         last_ff <= sts.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            step_ff <= '0;
            neg_ff  <= req_value[VALUE_WIDTH-1];
         end else begin
            if (cmd.convert) begin
               step_ff <= STEP_BITS'(step_ff + 1'b1);
            end
            // drop the sign once it has gone out
            if (cmd.emit) begin
               neg_ff <= 1'b0;
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.conv_done = (step_ff == STEP_BITS'(CONV_STEPS - 1));
   assign sts.emit_last = !neg_ff && (idx_ff == '0);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_char       = char_ff;
   assign rsp_running_length = rlen_ff;
   assign rsp_last           = last_ff;

endmodule

@@ design/signed_int_to_decimal_ascii_top.sv @@
`timescale 1ns / 1ps
// channel   direction  handshake             payload
// req_      in         req_valid/req_ready   req_value (32, signed), req_base_length (16)
// rsp_      out        rsp_valid/rsp_ready   rsp_out_char (8), rsp_running_length (16),
//                                            rsp_last (1)
//
// One request is accepted, converted (double dabble, four bits per cycle), has its
// digits counted, then is sent one character at a time.
// Characters go out one per cycle while rsp_ready is high, through a single output register.
// A stalled rsp_ready holds the output register and the character sequencer.
// Reset is synchronous and clears the controller and the output valid.
module signed_int_to_decimal_ascii_top
   import sitda_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  logic [LEN_BITS-1:0]           req_base_length,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [CHAR_BITS-1:0]          rsp_out_char,
   output logic [LEN_BITS-1:0]           rsp_running_length,
   output logic                          rsp_last
);

   cmd_type cmd;
   sts_type sts;

   sitda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sitda_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_value          (req_value),
      .req_base_length    (req_base_length),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_out_char       (rsp_out_char),
      .rsp_running_length (rsp_running_length),
      .rsp_last           (rsp_last)
   );

endmodule

@@ design/sitda_checker.sv @@
`timescale 1ns / 1ps
module sitda_checker
   import sitda_pkg::*;
(
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic signed [VALUE_WIDTH-1:0] req_value,
   input logic [LEN_BITS-1:0]           req_base_length,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [CHAR_BITS-1:0]          rsp_out_char,
   input logic [LEN_BITS-1:0]           rsp_running_length,
   input logic                          rsp_last
);

   // a waiting result holds still
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char)
         && $stable(rsp_running_length) && $stable(rsp_last))
      else $error("rsp changed while stalled");

   // a request in flight blocks the next one
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after accept");

   // only a minus sign or a digit goes out
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_char == CH_MINUS) ||
                    ((rsp_out_char >= CH_ZERO) && (rsp_out_char <= CH_ZERO + 8'd9)))
      else $error("rsp_out_char not a sign or digit");

   // when idle, a pending result can only be the final character
   assert property (@(posedge clock) disable iff (reset)
      req_ready && rsp_valid |-> rsp_last)
      else $error("idle with a non-final character pending");

endmodule

bind signed_int_to_decimal_ascii_top sitda_checker u_checker (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench
   import sitda_pkg::*;
;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_NUMBERS = 151;

   typedef struct packed {
      logic [CHAR_BITS-1:0] code;
      logic [LEN_BITS-1:0]  length;
      logic                 last;
   } ascii_char_type;

   // Spells each accepted number into the characters the block must send.
   class decimal_board_type;
      ascii_char_type       awaited_chars[$];
      int                   fails;
      logic [LEN_BITS-1:0]  run_len;
      int                   chars_left;

      function new();
         fails = 0;
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         fails++;
      endtask

      function void add_char(logic [CHAR_BITS-1:0] code);
         ascii_char_type c;
         if (run_len != LEN_MAX) run_len++;
         chars_left--;
         c.code   = code;
         c.length = run_len;
         c.last   = (chars_left == 0);
         awaited_chars.push_back(c);
      endfunction

      function void note_number(logic signed [VALUE_WIDTH-1:0] value,
                                logic [LEN_BITS-1:0] base_length);
         logic [VALUE_WIDTH-1:0] mag;
         logic [NIB_BITS-1:0]    digs[DIGITS];
         logic                   neg;
         int                     nd;
         neg = value[VALUE_WIDTH-1];
         mag = value;
         // the most negative value wraps to itself, which read unsigned is the true magnitude
         if (neg) mag = ~mag + 1'b1;
         nd = 0;
         do begin
            digs[nd] = NIB_BITS'(mag % RADIX);
            nd++;
            mag = mag / RADIX;
         end while (mag != 0);
         run_len    = base_length;
         chars_left = nd + (neg ? 1 : 0);
         if (neg) add_char(CH_MINUS);
         for (int k = nd - 1; k >= 0; k--) add_char(CH_ZERO + digs[k]);
      endfunction

      task check_char(logic [CHAR_BITS-1:0] code, logic [LEN_BITS-1:0] length, logic last);
         ascii_char_type e;
         if (awaited_chars.size() == 0) begin
            report($sformatf("char %0d len %0d last %0b with no number pending",
                             code, length, last));
            return;
         end
         e = awaited_chars.pop_front();
         if (code !== e.code)
            report($sformatf("out_char got %0d expected %0d", code, e.code));
         if (length !== e.length)
            report($sformatf("running_length got %0d expected %0d", length, e.length));
         if (last !== e.last)
            report($sformatf("last got %b expected %b", last, e.last));
      endtask
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic signed [VALUE_WIDTH-1:0] req_value = '0;
   logic [LEN_BITS-1:0]           req_base_length = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [CHAR_BITS-1:0]          rsp_out_char;
   logic [LEN_BITS-1:0]           rsp_running_length;
   logic                          rsp_last;

   logic                          quiet = 1'b0;
   logic                          hold_rsp = 1'b0;
   decimal_board_type             board = new();

   signed_int_to_decimal_ascii_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_value          (req_value),
      .req_base_length    (req_base_length),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_char       (rsp_out_char),
      .rsp_running_length (rsp_running_length),
      .rsp_last           (rsp_last)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int pick_gap(logic steady);
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Offer one number, hold it until accepted, then maybe go idle.
   task send_number(logic signed [VALUE_WIDTH-1:0] value, logic [LEN_BITS-1:0] base_length);
      int gap;
      req_valid       <= 1'b1;
      req_value       <= value;
      req_base_length <= base_length;
      do @(posedge clock); while (!req_ready);
      board.note_number(value, base_length);
      gap = pick_gap(quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task send_random_number();
      logic [VALUE_WIDTH-1:0]        mag;
      logic signed [VALUE_WIDTH-1:0] value;
      logic [LEN_BITS-1:0]           base_length;
      int                            r;
      if ($urandom_range(0, 3) == 0) begin
         value = $urandom;
      end else begin
         // shift to spread the digit count evenly-ish over 1..10
         mag   = $urandom >> $urandom_range(0, VALUE_WIDTH - 1);
         value = $urandom_range(0, 1) ? -mag : mag;
      end
      r = $urandom_range(0, 9);
      if (r < 2)      base_length = LEN_BITS'(LEN_MAX - $urandom_range(0, 12));
      else if (r < 4) base_length = LEN_BITS'($urandom_range(0, 20));
      else            base_length = LEN_BITS'($urandom);
      send_number(value, base_length);
   endtask

   // Receiver side: check each accepted character, then pick the next ready.
   initial begin
      int idle_left;
      idle_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            board.check_char(rsp_out_char, rsp_running_length, rsp_last);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
         end else if (idle_left > 0) begin
            rsp_ready <= 1'b0;
            idle_left--;
         end else begin
            rsp_ready <= 1'b1;
            idle_left = pick_gap(quiet);
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_number(0, 0);
      send_number(1, 16'hFFFF);
      send_number(-1, 16'hFFFE);
      send_number(9, 16'h5555);
      send_number(-10, 16'hAAAA);
      send_number(99, 100);
      send_number(-100, 65533);
      send_number(32'sh7FFFFFFF, 0);
      send_number(32'sh80000000, 0);
      send_number(32'sh80000000, 16'hFFFF);
      send_number(32'sh80000001, 65530);
      send_number(1000000000, 65528);
      send_number(999999999, 7);
      send_number(-999999999, 65534);
      send_number(-123456789, 16'h00FF);
      send_number(42, 16'hFF00);
      send_number(-5, 0);
      send_number(32'sh55555555, 0);
      send_number(32'shAAAAAAAA, 1);

      // first stretch back to back on both sides
      quiet <= 1'b1;
      for (int i = 0; i < RANDOM_NUMBERS; i++) begin
         if (i == 60) quiet <= 1'b0;
         if (i == 90) begin
            // stall the receiver long enough for the block to back up its input
            fork
               begin
                  hold_rsp <= 1'b1;
                  repeat (400) @(posedge clock);
                  hold_rsp <= 1'b0;
               end
            join_none
         end
         send_random_number();
      end
      req_valid <= 1'b0;

      while (board.awaited_chars.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.fails == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
